@@ sv/fau_pkg.sv @@
// Package for the fraction arithmetic unit: operation codes, status codes,
// widths and the front-to-back work record type. No dependencies.
`default_nettype none
package fau_pkg;
	localparam int OperandWidthDefault = 32;
	localparam int QueueDepthDefault = 2;
	localparam int MagWidth = 64;
	localparam int DenWidth = 62;

	localparam logic [2:0] MODE_REDUCE = 3'd1;
	localparam logic [2:0] MODE_ADD    = 3'd2;
	localparam logic [2:0] MODE_SUB    = 3'd3;
	localparam logic [2:0] MODE_MUL    = 3'd4;
	localparam logic [2:0] MODE_DIV    = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_BAD_MODE = 2'd3;

	typedef struct packed {
		logic [1:0]          status;
		logic                neg;
		logic [MagWidth-1:0] num_mag;
		logic [MagWidth-1:0] den_mag;
	} work_t;
endpackage
`default_nettype wire

@@ sv/fau_front.sv @@
// Front end: accepts a transaction, checks it and forms the raw numerator and
// denominator magnitudes with a shared W x W multiplier. Depends on fau_pkg.
`default_nettype none
module fau_front #(
	parameter int OPERAND_WIDTH = fau_pkg::OperandWidthDefault
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [2:0]                 mode,
	input  wire logic [OPERAND_WIDTH-1:0]   n1,
	input  wire logic [OPERAND_WIDTH-1:0]   d1,
	input  wire logic [OPERAND_WIDTH-1:0]   n2,
	input  wire logic [OPERAND_WIDTH-1:0]   d2,
	output logic                            wk_valid,
	input  wire logic                       wk_ready,
	output fau_pkg::work_t                  wk
);
	import fau_pkg::*;
	localparam int W = OPERAND_WIDTH;

	typedef enum logic [2:0] {S_IDLE, S_M0, S_M1, S_M2, S_SUM, S_OUT} state_t;

	state_t        state_q;
	logic [2:0]    mode_q;
	logic [W-1:0]  an1_q, ad1_q, an2_q, ad2_q;
	logic          sn1_q, sd1_q, sn2_q, sd2_q;
	logic [63:0]   p_q, q_q;
	logic          pn_q, qn_q;
	work_t         wk_q;

	logic [W-1:0]  ma, mb;
	logic [63:0]   prod;
	logic [1:0]    chk;
	logic [63:0]   sum_mag;
	logic          sum_neg, qneg;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		mag_of = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		ma = an1_q;
		mb = ad2_q;
		case (state_q)
			S_M0: begin
				ma = (mode_q == MODE_MUL) ? an1_q : ((mode_q == MODE_REDUCE) ? an1_q : an1_q);
				mb = (mode_q == MODE_MUL) ? an2_q : ad2_q;
			end
			S_M1: begin
				ma = (mode_q == MODE_MUL) ? ad1_q : ((mode_q == MODE_DIV) ? ad1_q : an2_q);
				mb = (mode_q == MODE_MUL) ? ad2_q : ((mode_q == MODE_DIV) ? an2_q : ad1_q);
			end
			S_M2: begin
				ma = ad1_q;
				mb = ad2_q;
			end
			default: begin
				ma = an1_q;
				mb = ad2_q;
			end
		endcase
		prod = 64'(ma) * 64'(mb);
	end

	always_comb begin
		if (ad1_q == '0) chk = ST_ZERO_DEN;
		else if (mode_q > MODE_REDUCE && ad2_q == '0) chk = ST_ZERO_DEN;
		else if (mode_q < MODE_REDUCE || mode_q > MODE_DIV) chk = ST_BAD_MODE;
		else if (mode_q == MODE_DIV && an2_q == '0) chk = ST_DIV_ZERO;
		else chk = ST_OK;
	end

	always_comb begin
		qneg = (mode_q == MODE_SUB) ? ((q_q != '0) && !qn_q) : qn_q;
		if (pn_q == qneg) begin
			sum_mag = p_q + q_q;
			sum_neg = pn_q;
		end else if (p_q >= q_q) begin
			sum_mag = p_q - q_q;
			sum_neg = pn_q;
		end else begin
			sum_mag = q_q - p_q;
			sum_neg = qneg;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	assign in_ready = (state_q == S_IDLE);
	assign wk_valid = (state_q == S_OUT);
	assign wk = wk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_M0;
				S_M0: begin
					if (chk != ST_OK) state_q <= S_OUT;
					else if (mode_q == MODE_REDUCE) state_q <= S_OUT;
					else state_q <= S_M1;
				end
				S_M1: state_q <= (mode_q == MODE_ADD || mode_q == MODE_SUB) ? S_M2 : S_OUT;
				S_M2: state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: if (wk_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= mode;
				an1_q <= mag_of(n1); sn1_q <= n1[W-1];
				ad1_q <= mag_of(d1); sd1_q <= d1[W-1];
				an2_q <= mag_of(n2); sn2_q <= n2[W-1];
				ad2_q <= mag_of(d2); sd2_q <= d2[W-1];
			end
			S_M0: begin
				wk_q.status <= chk;
				if (chk != ST_OK) begin
					wk_q.neg <= 1'b0;
					wk_q.num_mag <= '0;
					wk_q.den_mag <= '0;
				end else if (mode_q == MODE_REDUCE) begin
					wk_q.num_mag <= 64'(an1_q);
					wk_q.den_mag <= 64'(ad1_q);
					wk_q.neg <= (an1_q != '0) && (sn1_q != sd1_q);
				end else begin
					p_q <= prod;
					pn_q <= (prod != '0) &&
						(sn1_q != ((mode_q == MODE_MUL) ? sn2_q : sd2_q));
				end
			end
			S_M1: begin
				if (mode_q == MODE_MUL || mode_q == MODE_DIV) begin
					wk_q.num_mag <= p_q;
					wk_q.den_mag <= prod;
					wk_q.neg <= (p_q != '0) && (pn_q != (sd1_q != ((mode_q == MODE_MUL) ? sd2_q : sn2_q)));
				end else begin
					q_q <= prod;
					qn_q <= (prod != '0) && (sn2_q != sd1_q);
				end
			end
			S_M2: begin
				wk_q.den_mag <= prod;
			end
			S_SUM: begin
				wk_q.num_mag <= sum_mag;
				wk_q.neg <= (sum_mag != '0) && (sum_neg != (sd1_q != sd2_q));
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ sv/fau_queue.sv @@
// Short queue between the front and back ends of the fraction unit.
// Depends on fau_pkg for the work record type.
`default_nettype none
module fau_queue #(
	parameter int DEPTH = fau_pkg::QueueDepthDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire fau_pkg::work_t wr_data,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output fau_pkg::work_t      rd_data
);
	import fau_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t            mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             wr_en, rd_en;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

@@ sv/fau_back.sv @@
// Back end: binary gcd one step per cycle, then two restoring divisions by the
// gcd, one quotient bit per cycle, and the output register. Depends on fau_pkg.
`default_nettype none
module fau_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wk_valid,
	output logic                wk_ready,
	input  wire fau_pkg::work_t wk,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [63:0]         res_num,
	output logic [61:0]         res_den,
	output logic [1:0]          res_status
);
	import fau_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_OUT} state_t;

	state_t        state_q;
	logic [63:0]   u_q, v_q, g_q, nm_q, dm_q, rem_q, quo_q;
	logic [6:0]    sh_q, cnt_q;
	logic [1:0]    st_q;
	logic          neg_q;
	logic [63:0]   u_sub;
	logic [64:0]   trial;

	assign wk_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign u_sub = (u_q > v_q) ? (u_q - v_q) : (v_q - u_q);
	assign trial = {rem_q, quo_q[63]} - {1'b0, g_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (wk_valid) begin
						st_q <= wk.status;
						neg_q <= wk.neg;
						nm_q <= wk.num_mag;
						dm_q <= wk.den_mag;
						u_q <= wk.num_mag;
						v_q <= wk.den_mag;
						sh_q <= '0;
						state_q <= (wk.status != ST_OK) ? S_OUT : S_GCD;
						res_num <= '0;
						res_den <= '0;
						res_status <= wk.status;
					end
				end
				S_GCD: begin
					if (u_q == '0 || v_q == '0 || u_q == v_q) begin
						g_q <= (u_q == '0 && v_q == '0) ? 64'd1 :
							((u_q == '0) ? v_q << sh_q : u_q << sh_q);
						rem_q <= '0;
						quo_q <= nm_q;
						cnt_q <= '0;
						state_q <= S_DIVN;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1; v_q <= v_q >> 1; sh_q <= sh_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else begin
						u_q <= (u_q > v_q) ? u_sub >> 1 : u_q;
						v_q <= (u_q > v_q) ? v_q : u_sub >> 1;
					end
				end
				S_DIVN, S_DIVD: begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd63) begin
						if (state_q == S_DIVN) begin
							nm_q <= {quo_q[62:0], !trial[64]};
							rem_q <= '0;
							quo_q <= dm_q;
							cnt_q <= '0;
							state_q <= S_DIVD;
						end else begin
							res_num <= (neg_q && nm_q != '0) ? (64'd0 - nm_q) : nm_q;
							res_den <= {quo_q[60:0], !trial[64]};
							res_status <= ST_OK;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/fraction_arithmetic_unit.sv @@
// Top level of the fraction arithmetic unit: front end, work queue, back end.
// Depends on fau_pkg, fau_front, fau_queue and fau_back.
//
// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   tdata: mode[2:0], n1, d1, n2, d2 (OPERAND_WIDTH each), zero pad
// m_axis    out  tdata: result_numerator[63:0], result_denominator[61:0], status[1:0]
//
// The front end steps through its multiply and sum states per transaction; the
// back end's run time is set by the one-step gcd and two 64-step divisions.
// Reset is asynchronous and clears all control state; no clearing pass.
// Either side may stall; the queue lets the front end run ahead.
`default_nettype none
module fraction_arithmetic_unit #(
	parameter int OPERAND_WIDTH = fau_pkg::OperandWidthDefault,
	parameter int QUEUE_DEPTH = fau_pkg::QueueDepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// mode, first_numerator, first_denominator, second_numerator, second_denominator
	input  wire logic [((3+4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// result_numerator, result_denominator, status
	output logic [127:0] m_axis_tdata
);
	import fau_pkg::*;
	localparam int W = OPERAND_WIDTH;

	logic   f_valid, f_ready, b_valid, b_ready;
	work_t  f_wk, b_wk;
	logic [63:0] rn;
	logic [61:0] rd;
	logic [1:0]  rs;

	fau_front #(.OPERAND_WIDTH(W)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mode(s_axis_tdata[2:0]),
		.n1(s_axis_tdata[3 +: W]), .d1(s_axis_tdata[3+W +: W]),
		.n2(s_axis_tdata[3+2*W +: W]), .d2(s_axis_tdata[3+3*W +: W]),
		.wk_valid(f_valid), .wk_ready(f_ready), .wk(f_wk)
	);

	fau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_wk),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_wk)
	);

	fau_back u_back (
		.clk, .arst_n,
		.wk_valid(b_valid), .wk_ready(b_ready), .wk(b_wk),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.res_num(rn), .res_den(rd), .res_status(rs)
	);

	assign m_axis_tdata = {rs, rd, rn};
endmodule
`default_nettype wire

@@ sv/fau_checker.sv @@
// Port-level checker for the fraction arithmetic unit, bound to the top level.
// Depends on fau_pkg for status codes.
`default_nettype none
module fau_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [127:0] m_axis_tdata
);
	import fau_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result changed while stalled.");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[127:126] != ST_OK |-> m_axis_tdata[125:0] == '0)
		else $error("Error result carries a nonzero fraction.");
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[127:126] == ST_OK && m_axis_tdata[63:0] == '0
		|-> m_axis_tdata[125:64] == 62'd1)
		else $error("Good zero result without a unit denominator.");
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input accepted while a transaction is in the front end.");
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("Result shown during reset.");
endmodule

bind fraction_arithmetic_unit fau_checker u_fau_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
